// ----- design/salc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, field widths, codes and helpers of the LRU cache simulator.
// ----------------------------------------------------------------------------
package salc_pkg;

    // Default storage geometry
    localparam int MAX_SETS_DEF = 64;
    localparam int MAX_WAYS_DEF = 8;

    // Input field widths
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 32;
    localparam int TAG_W    = ADDR_W;

    // Configuration register widths and indexes
    localparam int SET_BITS_W   = 3;
    localparam int WAYS_W       = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int SHAMT_W      = 6;
    // Widest set field before the wrap onto the stored sets
    localparam int SET_RAW_W    = (1 << SET_BITS_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

    // Result fields
    localparam int HITS_W        = 2;
    localparam int TOTAL_W       = 32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;
    localparam int OUT_FIELDS_W  = HITS_W + 2 + 3 * TOTAL_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Control into the way scan unit
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    // Status out of the way scan unit
    typedef struct packed {
        logic found;
        logic have_free;
        logic have_victim;
    } scan_flags_t;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
    endfunction

endpackage
`default_nettype wire

// ----- design/set_assoc_lru_cache_sim_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core
// Set-associative cache simulator with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transaction per trace access. s_tuser carries the
//   action (load, store, modify), s_tdata the byte address. Each accepted
//   transaction yields exactly one result transaction on the m_ side with
//   the hit/miss/eviction flags of the access and the saturating totals.
//   Configuration (set bits, ways, block bits) is written through the
//   cfg_we / cfg_index / cfg_wdata port while no access is in flight.
//   Timing: an access passes the decode, scan and update states in turn;
//   the next access is accepted only once the block is back in idle. The
//   single tag/rank compare unit visits one way of the set per cycle.
//   Reset: after aresetn the block sweeps the line store, one set per
//   cycle, over MAX_SETS sets (64 by default); s_tready stays low until
//   the sweep ends. Configuration writes are taken during the sweep.
//   Back-pressure: the result waits in the output register while m_tready
//   is low; the next access is accepted and processed meanwhile and holds
//   in its final step until the output register frees up.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core
    import salc_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    // access stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [ADDR_W-1:0]       s_tdata,   // [31:0] address
    input  wire logic [ACTION_W-1:0]     s_tuser,   // [1:0] action
    // result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [1:0] hits_added, [2] missed, [3] evicted, [35:4] total_hits,
    // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
    output logic [OUT_TDATA_W-1:0]       m_tdata
);
    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int VCNT_W    = $clog2(MAX_WAYS + 1);
    localparam int CMP_W     = (VCNT_W > WAYS_W) ? VCNT_W : WAYS_W;
    localparam int ENTRY_W   = WAY_W + TAG_W + 1;   // {rank, tag, valid}
    localparam int ROW_W     = MAX_WAYS * ENTRY_W;
    localparam int SET_TAB_N = 1 << SET_RAW_W;
    localparam int PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DECODE = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_UPDATE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SET_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [WAY_W-1:0]        way_cnt_reg, way_cnt_next;

    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [WAYS_W-1:0]       ways_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;

    logic [ACTION_W-1:0]     action_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [SET_W-1:0]        set_reg;

    logic [TOTAL_W-1:0]      hit_total_reg, hit_total_next;
    logic [TOTAL_W-1:0]      miss_total_reg, miss_total_next;
    logic [TOTAL_W-1:0]      evict_total_reg, evict_total_next;

    logic                    m_tvalid_reg;
    logic [HITS_W-1:0]       hits_added_reg;
    logic                    missed_reg;
    logic                    evicted_reg;

    // ------------------------------------------------------------------
    // Address split: tag above set_bits + block_bits, set wraps onto the
    // stored sets through a constant table.
    // ------------------------------------------------------------------
    logic [SHAMT_W-1:0]      tag_shamt;
    logic [TAG_W-1:0]        tag_calc;
    logic [ADDR_W-1:0]       set_shifted;
    logic [SET_RAW_W-1:0]    set_mask;
    logic [SET_RAW_W-1:0]    set_raw;
    logic [SET_W-1:0]        set_calc;
    logic [SET_W-1:0]        set_mod_tab [SET_TAB_N];

    for (genvar i = 0; i < SET_TAB_N; i++) begin : g_set_tab
        assign set_mod_tab[i] = SET_W'(i % MAX_SETS);
    end

    assign tag_shamt   = SHAMT_W'(set_bits_reg) + SHAMT_W'(block_bits_reg);
    assign tag_calc    = addr_reg >> tag_shamt;   // zero once the shift reaches 32
    assign set_shifted = addr_reg >> block_bits_reg;
    assign set_mask    = SET_RAW_W'((8'd1 << set_bits_reg) - 8'd1);
    assign set_raw     = set_shifted[SET_RAW_W-1:0] & set_mask;
    assign set_calc    = set_mod_tab[set_raw];

    // ------------------------------------------------------------------
    // Line store: one row per set, all ways side by side.
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [ROW_W-1:0]   ram_rdata;
    logic [ROW_W-1:0]   new_row;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_DECODE),
        .raddr (set_calc),
        .rdata (ram_rdata)
    );

    logic [ENTRY_W-1:0] row_ent [MAX_WAYS];
    logic [ENTRY_W-1:0] upd_ent [MAX_WAYS];
    logic [ENTRY_W-1:0] cur_ent;

    // ------------------------------------------------------------------
    // Way scan: one way per cycle through the shared compare unit.
    // ------------------------------------------------------------------
    scan_ctrl_t         scan_ctrl;
    scan_flags_t        scan_flags;
    logic [WAY_W-1:0]   hit_way, best_rank, free_way, victim_way, worst_rank;
    logic [VCNT_W-1:0]  valid_count;

    assign cur_ent         = row_ent[way_cnt_reg];
    assign scan_ctrl.clear = (state_reg == ST_DECODE);
    assign scan_ctrl.step  = (state_reg == ST_SCAN);

    salc_way_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (scan_ctrl),
        .key_tag     (tag_reg),
        .way_idx     (way_cnt_reg),
        .way_valid   (cur_ent[0]),
        .way_tag     (cur_ent[TAG_W:1]),
        .way_rank    (cur_ent[ENTRY_W-1 -: WAY_W]),
        .flags       (scan_flags),
        .hit_way     (hit_way),
        .best_rank   (best_rank),
        .free_way    (free_way),
        .victim_way  (victim_way),
        .worst_rank  (worst_rank),
        .valid_count (valid_count)
    );

    // ------------------------------------------------------------------
    // Replacement decision
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] eff_ways;
    logic             fill_ok;
    logic             do_hit, do_fill, do_evict;
    logic             access_en;
    logic             is_modify;

    always_comb begin
        if (ways_reg == '0) begin
            eff_ways = CMP_W'(1);
        end else if (CMP_W'(ways_reg) > CMP_W'(MAX_WAYS)) begin
            eff_ways = CMP_W'(MAX_WAYS);
        end else begin
            eff_ways = CMP_W'(ways_reg);
        end
    end

    assign access_en = action_reg inside {ACT_LOAD, ACT_STORE, ACT_MODIFY};
    assign is_modify = (action_reg == ACT_MODIFY);
    assign fill_ok   = (CMP_W'(valid_count) < eff_ways);
    assign do_hit    = scan_flags.found;
    assign do_fill   = !scan_flags.found && fill_ok && scan_flags.have_free;
    assign do_evict  = !scan_flags.found && !do_fill;

    // Rank update of every way in parallel. A modify's second access hits
    // the line just made most recent and leaves the set as it is.
    for (genvar k = 0; k < MAX_WAYS; k++) begin : g_way
        logic             ent_valid;
        logic [TAG_W-1:0] ent_tag;
        logic [WAY_W-1:0] ent_rank;

        assign row_ent[k] = ram_rdata[k*ENTRY_W +: ENTRY_W];
        assign ent_valid  = row_ent[k][0];
        assign ent_tag    = row_ent[k][TAG_W:1];
        assign ent_rank   = row_ent[k][ENTRY_W-1 -: WAY_W];

        always_comb begin
            upd_ent[k] = row_ent[k];
            if (do_hit) begin
                if (ent_valid && ent_rank < best_rank) begin
                    upd_ent[k] = {ent_rank + WAY_W'(1), ent_tag, ent_valid};
                end
                if (hit_way == WAY_W'(k)) begin
                    upd_ent[k] = {WAY_W'(0), ent_tag, ent_valid};
                end
            end else if (do_fill) begin
                if (ent_valid) begin
                    upd_ent[k] = {ent_rank + WAY_W'(1), ent_tag, ent_valid};
                end
                if (free_way == WAY_W'(k)) begin
                    upd_ent[k] = {WAY_W'(0), tag_reg, 1'b1};
                end
            end else begin
                if (ent_valid && ent_rank < worst_rank) begin
                    upd_ent[k] = {ent_rank + WAY_W'(1), ent_tag, ent_valid};
                end
                if (victim_way == WAY_W'(k)) begin
                    upd_ent[k] = {WAY_W'(0), tag_reg, ent_valid};
                end
            end
        end

        assign new_row[k*ENTRY_W +: ENTRY_W] = upd_ent[k];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_free;
    logic finish;

    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_UPDATE) && out_free;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        way_cnt_next = way_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(MAX_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                way_cnt_next = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                way_cnt_next = way_cnt_reg + WAY_W'(1);
                if (way_cnt_reg == WAY_W'(MAX_WAYS - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Store writes: zero rows during the sweep, the updated row at the end
    // of a valid access.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = new_row;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (finish && access_en) begin
            ram_we = 1'b1;
        end
    end

    // Running totals
    always_comb begin
        hit_total_next   = hit_total_reg;
        miss_total_next  = miss_total_reg;
        evict_total_next = evict_total_reg;
        if (access_en) begin
            if (do_hit) begin
                hit_total_next = sat_inc(hit_total_reg);
            end else begin
                miss_total_next = sat_inc(miss_total_reg);
            end
            if (do_evict) begin
                evict_total_next = sat_inc(evict_total_reg);
            end
            if (is_modify) begin
                hit_total_next = sat_inc(hit_total_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            way_cnt_reg     <= '0;
            set_bits_reg    <= '0;
            ways_reg        <= WAYS_W'(1);
            block_bits_reg  <= '0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            way_cnt_reg <= way_cnt_next;

            if (cfg_we) begin
                case (cfg_index)
                    REG_SET_BITS:   set_bits_reg   <= cfg_wdata[SET_BITS_W-1:0];
                    REG_WAYS:       ways_reg       <= cfg_wdata[WAYS_W-1:0];
                    REG_BLOCK_BITS: block_bits_reg <= cfg_wdata[BLOCK_BITS_W-1:0];
                    default: ;  // drop writes to unused indexes
                endcase
            end

            if (finish) begin
                hit_total_reg   <= hit_total_next;
                miss_total_reg  <= miss_total_next;
                evict_total_reg <= evict_total_next;
            end

            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= s_tuser;
            addr_reg   <= s_tdata;
        end
        if (state_reg == ST_DECODE) begin
            tag_reg <= tag_calc;
            set_reg <= set_calc;
        end
        if (finish) begin
            hits_added_reg <= access_en ? (HITS_W'(do_hit) + HITS_W'(is_modify)) : '0;
            missed_reg     <= access_en && !do_hit;
            evicted_reg    <= access_en && do_evict;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {PAD_W'(0), evict_total_reg, miss_total_reg, hit_total_reg,
                       evicted_reg, missed_reg, hits_added_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // m_tvalid is registered as the access leaves the update state, after the
    // decode and scan states, and is sampled high from the following edge on.
    a_result_in_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> ##(MAX_WAYS + 3) m_tvalid)
        else $error("result not shown in time after an accepted access");

    a_hits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (hit_total_reg >= $past(hit_total_reg)))
        else $error("hit total decreased");

    a_evict_needs_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && evicted_reg) |-> (missed_reg && hits_added_reg != HITS_W'(2)))
        else $error("eviction reported without a miss");

endmodule
`default_nettype wire

// ----- design/salc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/salc_way_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salc_way_scan
// Shared tag compare and rank compare unit, one way per step. Tracks the
// most recent matching line, the first free way, the least recent line
// and the number of valid lines of the set.
// ----------------------------------------------------------------------------
module salc_way_scan
    import salc_pkg::*;
#(
    parameter int MAX_WAYS = MAX_WAYS_DEF,
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int VCNT_W = $clog2(MAX_WAYS + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire scan_ctrl_t        ctrl,
    input  wire logic [TAG_W-1:0]  key_tag,
    input  wire logic [WAY_W-1:0]  way_idx,
    input  wire logic              way_valid,
    input  wire logic [TAG_W-1:0]  way_tag,
    input  wire logic [WAY_W-1:0]  way_rank,
    output scan_flags_t            flags,
    output logic      [WAY_W-1:0]  hit_way,
    output logic      [WAY_W-1:0]  best_rank,
    output logic      [WAY_W-1:0]  free_way,
    output logic      [WAY_W-1:0]  victim_way,
    output logic      [WAY_W-1:0]  worst_rank,
    output logic      [VCNT_W-1:0] valid_count
);
    scan_flags_t       flags_reg;
    logic [VCNT_W-1:0] count_reg;
    logic              match;

    assign match = way_valid && (way_tag == key_tag);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            flags_reg <= '0;
            count_reg <= '0;
        end else if (ctrl.step) begin
            // most recent match wins
            if (match && (!flags_reg.found || way_rank < best_rank)) begin
                flags_reg.found <= 1'b1;
                best_rank       <= way_rank;
                hit_way         <= way_idx;
            end
            // lowest free way
            if (!way_valid && !flags_reg.have_free) begin
                flags_reg.have_free <= 1'b1;
                free_way            <= way_idx;
            end
            // least recent valid line
            if (way_valid && (!flags_reg.have_victim || way_rank > worst_rank)) begin
                flags_reg.have_victim <= 1'b1;
                worst_rank            <= way_rank;
                victim_way            <= way_idx;
            end
            if (way_valid) begin
                count_reg <= count_reg + VCNT_W'(1);
            end
        end
    end

    assign flags       = flags_reg;
    assign valid_count = count_reg;

endmodule
`default_nettype wire
